/* rtl/sli_pkg.sv */
package sli_pkg;

    // Table geometry
    localparam int CAPACITY = 64;
    localparam int IDX_W    = $clog2(CAPACITY);
    localparam int CNT_W    = $clog2(CAPACITY + 1);
    localparam int VAL_W    = 32;
    localparam int ENTRY_W  = 7;
    localparam int STATUS_W = 2;

    typedef enum logic {
        FN_INSERT = 1'b0,
        FN_DELETE = 1'b1
    } func_t;

    typedef enum logic [STATUS_W-1:0] {
        ST_DONE      = 2'd0,
        ST_NOT_FOUND = 2'd1,
        ST_FULL      = 2'd2
    } status_t;

    typedef enum logic [2:0] {
        S_IDLE,
        S_INS_CMP,
        S_INS_LAST,
        S_DEL_SCAN,
        S_FINISH
    } state_t;

endpackage

/* rtl/sorted_list_insert_delete_unit.sv */
// Sorted table of up to CAPACITY signed 32-bit values, kept in ascending
// order in a single-port-write, registered-read RAM. An insert places the
// value after all stored values that are less than or equal to it, so equal
// values keep arrival order; a full table refuses the insert with status
// "full". A delete removes the first stored copy of the value and closes the
// gap, or reports "not found". Every operation returns exactly one result
// with the status and the number of stored values afterward. The block takes
// one operation at a time and is busy until its result is ready. Timing is
// set by the RAM: one entry is read and compared per cycle. An insert walks
// down from the top of the table and moves each larger entry up by one,
// then writes the new value into the freed slot and posts the result. A
// delete scans the whole occupied part of the table, moving each entry after
// the match down by one, then posts the result. A full-table insert or a
// delete on an empty table skips the scan and posts its result directly.
// The result sits in an output register, so the next operation can be taken
// while the previous result still waits for its transfer.
module sorted_list_insert_delete_unit
    import sli_pkg::*;
(
    input  logic                    clk,
    input  logic                    rst_n,
    input  logic                    in_valid,
    output logic                    in_ready,
    input  logic                    func,
    input  logic signed [VAL_W-1:0] value,
    output logic                    out_valid,
    input  logic                    out_ready,
    output logic [STATUS_W-1:0]     status,
    output logic [ENTRY_W-1:0]      entry_count
);

    state_t                  state_reg, state_next;
    logic [CNT_W-1:0]        count_reg, count_next;
    logic [CNT_W-1:0]        idx_reg, idx_next;
    logic                    found_reg, found_next;
    func_t                   func_reg, func_next;
    logic signed [VAL_W-1:0] value_reg, value_next;
    status_t                 res_reg, res_next;
    logic                    out_valid_reg, out_valid_next;
    status_t                 out_status_reg, out_status_next;
    logic [ENTRY_W-1:0]      out_count_reg, out_count_next;

    logic                    wr_en;
    logic [IDX_W-1:0]        wr_addr;
    logic [VAL_W-1:0]        wr_data;
    logic [IDX_W-1:0]        rd_addr;
    logic [VAL_W-1:0]        rd_data;
    logic [CNT_W-1:0]        cnt_after;
    logic                    slot_free;

    sli_ram #(
        .WIDTH (VAL_W),
        .DEPTH (CAPACITY)
    ) u_ram (
        .clk     (clk),
        .wr_en   (wr_en),
        .wr_addr (wr_addr),
        .wr_data (wr_data),
        .rd_addr (rd_addr),
        .rd_data (rd_data)
    );

    assign slot_free = !out_valid_reg || out_ready;

    // Count after the operation: only a successful operation moves it
    always_comb
    begin
        cnt_after = count_reg;
        if (res_reg == ST_DONE)
        begin
            if (func_reg == FN_INSERT)
            begin
                cnt_after = count_reg + 1'b1;
            end
            else
            begin
                cnt_after = count_reg - 1'b1;
            end
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= S_IDLE;
            count_reg     <= '0;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            state_reg     <= state_next;
            count_reg     <= count_next;
            out_valid_reg <= out_valid_next;
        end
    end

    // Payload and working registers, no reset needed
    always_ff @(posedge clk)
    begin
        idx_reg        <= idx_next;
        found_reg      <= found_next;
        func_reg       <= func_next;
        value_reg      <= value_next;
        res_reg        <= res_next;
        out_status_reg <= out_status_next;
        out_count_reg  <= out_count_next;
    end

    always_comb
    begin
        state_next      = state_reg;
        count_next      = count_reg;
        idx_next        = idx_reg;
        found_next      = found_reg;
        func_next       = func_reg;
        value_next      = value_reg;
        res_next        = res_reg;
        out_valid_next  = out_valid_reg;
        out_status_next = out_status_reg;
        out_count_next  = out_count_reg;
        wr_en           = 1'b0;
        wr_addr         = '0;
        wr_data         = value_reg;
        rd_addr         = '0;
        in_ready        = 1'b0;

        // Drop the result once its transfer completes
        if (out_valid_reg && out_ready)
        begin
            out_valid_next = 1'b0;
        end

        unique case (state_reg)
            S_IDLE:
            begin
                in_ready = 1'b1;
                if (in_valid)
                begin
                    func_next  = func_t'(func);
                    value_next = value;
                    if (func_t'(func) == FN_INSERT)
                    begin
                        priority if (count_reg == CNT_W'(CAPACITY))
                        begin
                            res_next   = ST_FULL;
                            state_next = S_FINISH;
                        end
                        else if (count_reg == '0)
                        begin
                            state_next = S_INS_LAST;
                        end
                        else
                        begin
                            // Start at the top entry and walk down
                            rd_addr    = IDX_W'(count_reg - 1'b1);
                            idx_next   = count_reg;
                            state_next = S_INS_CMP;
                        end
                    end
                    else
                    begin
                        if (count_reg == '0)
                        begin
                            res_next   = ST_NOT_FOUND;
                            state_next = S_FINISH;
                        end
                        else
                        begin
                            rd_addr    = '0;
                            idx_next   = '0;
                            found_next = 1'b0;
                            state_next = S_DEL_SCAN;
                        end
                    end
                end
            end

            S_INS_CMP:
            begin
                // rd_data holds entry idx-1
                if ($signed(rd_data) > value_reg)
                begin
                    // Move the larger entry up one slot
                    wr_en    = 1'b1;
                    wr_addr  = idx_reg[IDX_W-1:0];
                    wr_data  = rd_data;
                    idx_next = idx_reg - 1'b1;
                    if (idx_reg == CNT_W'(1))
                    begin
                        state_next = S_INS_LAST;
                    end
                    else
                    begin
                        rd_addr = IDX_W'(idx_reg - CNT_W'(2));
                    end
                end
                else
                begin
                    wr_en      = 1'b1;
                    wr_addr    = idx_reg[IDX_W-1:0];
                    wr_data    = value_reg;
                    res_next   = ST_DONE;
                    state_next = S_FINISH;
                end
            end

            S_INS_LAST:
            begin
                wr_en      = 1'b1;
                wr_addr    = '0;
                wr_data    = value_reg;
                res_next   = ST_DONE;
                state_next = S_FINISH;
            end

            S_DEL_SCAN:
            begin
                // rd_data holds entry idx; prefetch the next one
                rd_addr  = IDX_W'(idx_reg + 1'b1);
                idx_next = idx_reg + 1'b1;
                if (found_reg)
                begin
                    // Close the gap: shift this entry down one slot
                    wr_en   = 1'b1;
                    wr_addr = IDX_W'(idx_reg - 1'b1);
                    wr_data = rd_data;
                end
                else if (rd_data == value_reg)
                begin
                    found_next = 1'b1;
                end
                if (idx_reg + 1'b1 == count_reg)
                begin
                    if (found_reg || (rd_data == value_reg))
                    begin
                        res_next = ST_DONE;
                    end
                    else
                    begin
                        res_next = ST_NOT_FOUND;
                    end
                    state_next = S_FINISH;
                end
            end

            S_FINISH:
            begin
                // Hold until the output register is free
                if (slot_free)
                begin
                    out_valid_next  = 1'b1;
                    out_status_next = res_reg;
                    out_count_next  = ENTRY_W'(cnt_after);
                    count_next      = cnt_after;
                    state_next      = S_IDLE;
                end
            end

            default:
            begin
                state_next = S_IDLE;
            end
        endcase
    end

    assign out_valid   = out_valid_reg;
    assign status      = out_status_reg;
    assign entry_count = out_count_reg;

    a_count_bound: assert property (@(posedge clk) disable iff (!rst_n)
        count_reg <= CNT_W'(CAPACITY))
        else $error("stored count exceeds capacity");

    a_full_count: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid && (status == ST_FULL) |-> entry_count == ENTRY_W'(CAPACITY))
        else $error("full status with table not at capacity");

    a_busy_after_accept: assert property (@(posedge clk) disable iff (!rst_n)
        in_valid && in_ready |=> !in_ready)
        else $error("accepted a second operation while busy");

    a_write_when_busy: assert property (@(posedge clk) disable iff (!rst_n)
        wr_en |-> (state_reg != S_IDLE) && (state_reg != S_FINISH))
        else $error("table write outside of an operation");

    a_insert_grows: assert property (@(posedge clk) disable iff (!rst_n)
        (state_reg == S_FINISH) && slot_free && (res_reg == ST_DONE)
        && (func_reg == FN_INSERT)
        |=> count_reg == $past(count_reg) + 1'b1)
        else $error("successful insert did not grow the table");

endmodule

/* rtl/sli_ram.sv */
module sli_ram #(
    parameter int WIDTH = 32,
    parameter int DEPTH = 64
) (
    input  logic                     clk,
    input  logic                     wr_en,
    input  logic [$clog2(DEPTH)-1:0] wr_addr,
    input  logic [WIDTH-1:0]         wr_data,
    input  logic [$clog2(DEPTH)-1:0] rd_addr,
    output logic [WIDTH-1:0]         rd_data
);

    logic [WIDTH-1:0] mem [DEPTH];

    always_ff @(posedge clk)
    begin
        if (wr_en)
        begin
            mem[wr_addr] <= wr_data;
        end
        rd_data <= mem[rd_addr];
    end

endmodule

/* bench/tb_top.sv */
module tb_top;
    import sli_pkg::*;

    timeunit 1ns;
    timeprecision 1ps;

    // Run-length guard. The slowest correct item is an insert into a nearly
    // full table that shifts every entry, behind a sender gap and a receiver
    // stall. Allow for that on every item, plus the long receiver hold, and
    // take it several times over.
    localparam int CYCLE_LIMIT     = 600000;
    localparam int TAIL_ITEMS      = 150;   // final stretch runs with no idling
    localparam int RANDOM_ITEMS    = 1130;
    localparam int HOLD_AFTER      = 300;   // results seen before the long hold
    localparam int HOLD_CYCLES     = 400;
    localparam int DRAIN_CYCLES    = 80;
    localparam int VMIN            = -2147483647 - 1;
    localparam int VMAX            = 2147483647;

    typedef struct {
        func_t                   fn;
        logic signed [VAL_W-1:0] val;
    } table_op_t;

    typedef struct {
        status_t            st;
        logic [ENTRY_W-1:0] count;
    } table_result_t;

    // DUT ports; every input starts at a known value
    logic                    clk         = 1'b0;
    logic                    rst_n       = 1'b0;
    logic                    in_valid    = 1'b0;
    logic                    in_ready;
    logic                    func        = FN_INSERT;
    logic signed [VAL_W-1:0] value       = '0;
    logic                    out_valid;
    logic                    out_ready   = 1'b0;
    logic [STATUS_W-1:0]     status;
    logic [ENTRY_W-1:0]      entry_count;

    // Operations still to be offered, and results still owed by the block
    table_op_t     queued_ops[$];
    table_result_t awaited_results[$];

    // Our own view of the sorted table, ascending, signed compare
    int            shadow_table[$];

    int  error_count  = 0;
    int  results_seen = 0;
    int  cycle_count  = 0;
    int  send_gap     = 0;
    int  stall_left   = 0;
    int  hold_left    = 0;
    bit  hold_done    = 1'b0;

    sorted_list_insert_delete_unit dut (
        .clk         (clk),
        .rst_n       (rst_n),
        .in_valid    (in_valid),
        .in_ready    (in_ready),
        .func        (func),
        .value       (value),
        .out_valid   (out_valid),
        .out_ready   (out_ready),
        .status      (status),
        .entry_count (entry_count)
    );

    initial
    begin
        forever #5 clk = ~clk;
    end

    // Apply one operation to the shadow table and return the result the
    // block must post for it. Inserts go after every equal value; deletes
    // take the first copy.
    function automatic table_result_t apply_table_op(table_op_t op);
        table_result_t res;
        int            pos;
        int            v;
        v   = op.val;
        pos = 0;
        if (op.fn == FN_INSERT)
        begin
            if (shadow_table.size() >= CAPACITY)
            begin
                res.st = ST_FULL;
            end
            else
            begin
                while (pos < shadow_table.size() && shadow_table[pos] <= v)
                    pos++;
                shadow_table.insert(pos, v);
                res.st = ST_DONE;
            end
        end
        else
        begin
            while (pos < shadow_table.size() && shadow_table[pos] != v)
                pos++;
            if (pos >= shadow_table.size())
            begin
                res.st = ST_NOT_FOUND;
            end
            else
            begin
                shadow_table.delete(pos);
                res.st = ST_DONE;
            end
        end
        res.count = ENTRY_W'(shadow_table.size());
        return res;
    endfunction

    // Most often a narrow band around zero so duplicates and matches are common,
    // some extremes of the signed range, and the rest fully random patterns.
    function automatic int pick_value();
        int r;
        r = $urandom_range(0, 99);
        if (r < 45)
            return int'($urandom_range(0, 16)) - 8;
        if (r < 60)
        begin
            case ($urandom_range(0, 5))
                0: return VMIN;
                1: return VMIN + 1;
                2: return VMAX - 1;
                3: return VMAX;
                4: return -1;
                default: return 0;
            endcase
        end
        return int'($urandom());
    endfunction

    function automatic void queue_op(func_t fn, int v);
        table_op_t op;
        op.fn  = fn;
        op.val = v;
        queued_ops.push_back(op);
    endfunction

    // Stimulus: a short directed opening, then rounds that fill, drain or mix.
    // Deletes mostly name a value that was inserted earlier so they hit.
    initial
    begin
        int live_values[$];
        int done_random;
        int mode;
        int round_len;
        int insert_pct;
        int idx;
        int v;
        bit first_round;

        // delete from an empty table, then duplicates and range extremes
        queue_op(FN_DELETE, 0);
        queue_op(FN_INSERT, 0);
        queue_op(FN_INSERT, 0);
        queue_op(FN_INSERT, VMIN);
        queue_op(FN_INSERT, VMAX);
        queue_op(FN_INSERT, -1);
        queue_op(FN_INSERT, 1);
        queue_op(FN_INSERT, VMAX);
        queue_op(FN_INSERT, VMIN);
        queue_op(FN_DELETE, 5);
        queue_op(FN_DELETE, VMAX - 1);
        queue_op(FN_DELETE, 0);
        queue_op(FN_DELETE, VMIN);
        queue_op(FN_DELETE, VMAX);
        queue_op(FN_DELETE, -1);
        queue_op(FN_DELETE, 1);
        queue_op(FN_DELETE, VMIN);
        queue_op(FN_DELETE, VMAX);
        queue_op(FN_DELETE, 0);
        queue_op(FN_DELETE, 0);

        done_random = 0;
        first_round = 1'b1;
        while (done_random < RANDOM_ITEMS)
        begin
            // the first round fills past capacity so the full case is hit early
            mode      = first_round ? 0 : $urandom_range(0, 2);
            round_len = first_round ? 90 : $urandom_range(20, 80);
            first_round = 1'b0;
            insert_pct = (mode == 0) ? 88 : (mode == 1) ? 15 : 50;
            for (int i = 0; i < round_len && done_random < RANDOM_ITEMS; i++)
            begin
                if ($urandom_range(0, 99) < insert_pct)
                begin
                    v = pick_value();
                    queue_op(FN_INSERT, v);
                    if (live_values.size() < CAPACITY)
                        live_values.push_back(v);
                end
                else if (live_values.size() > 0 && $urandom_range(0, 99) < 88)
                begin
                    idx = $urandom_range(0, live_values.size() - 1);
                    queue_op(FN_DELETE, live_values[idx]);
                    live_values.delete(idx);
                end
                else
                begin
                    queue_op(FN_DELETE, pick_value());
                end
                done_random++;
            end
        end

        // hold reset, then release it on a clock edge
        repeat (9) @(posedge clk);
        rst_n <= 1'b1;

        // wait for the last transfer in, then for every result to come back
        while (queued_ops.size() > 0 || in_valid)
            @(posedge clk);
        while (awaited_results.size() > 0)
            @(posedge clk);
        repeat (DRAIN_CYCLES) @(posedge clk);

        if (error_count == 0 && awaited_results.size() == 0)
            $display("ALL CHECKS PASSED");
        else
            $display("CHECKS FAILED");
        $finish;
    end

    // Driver: hold the payload while the block stalls, otherwise advance to
    // the next queued operation or insert a random idle burst.
    always @(posedge clk or negedge rst_n)
    begin
        table_op_t op;
        if (!rst_n)
        begin
            in_valid <= 1'b0;
            func     <= FN_INSERT;
            value    <= '0;
            send_gap <= 0;
        end
        else if (!in_valid || in_ready)
        begin
            if (send_gap > 0)
            begin
                in_valid <= 1'b0;
                send_gap <= send_gap - 1;
            end
            else if (queued_ops.size() > 0)
            begin
                op = queued_ops.pop_front();
                in_valid <= 1'b1;
                func     <= op.fn;
                value    <= op.val;
                // the gap starts once this transfer completes
                if (queued_ops.size() > TAIL_ITEMS && $urandom_range(0, 99) < 20)
                    send_gap <= $urandom_range(1, 9);
            end
            else
            begin
                in_valid <= 1'b0;
            end
        end
    end

    // Receiver: short random stalls, plus one long hold-off while the sender
    // keeps offering, so the output register fills and the input backs up.
    always @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            out_ready  <= 1'b0;
            stall_left <= 0;
            hold_left  <= 0;
            hold_done  <= 1'b0;
        end
        else if (hold_left > 0)
        begin
            out_ready <= 1'b0;
            hold_left <= hold_left - 1;
        end
        else if (!hold_done && results_seen >= HOLD_AFTER)
        begin
            out_ready <= 1'b0;
            hold_left <= HOLD_CYCLES;
            hold_done <= 1'b1;
        end
        else if (stall_left > 0)
        begin
            out_ready  <= 1'b0;
            stall_left <= stall_left - 1;
        end
        else if (queued_ops.size() > TAIL_ITEMS && $urandom_range(0, 99) < 15)
        begin
            out_ready  <= 1'b0;
            stall_left <= $urandom_range(0, 8);
        end
        else
        begin
            out_ready <= 1'b1;
        end
    end

    // Monitor: check an outgoing transfer against the oldest expectation
    // first, then record the expectation for an incoming transfer. A result
    // can never leave on the same edge its operation enters.
    always @(posedge clk)
    begin
        table_result_t want;
        table_op_t     taken;
        if (rst_n)
        begin
            if (out_valid && out_ready)
            begin
                results_seen <= results_seen + 1;
                if (awaited_results.size() == 0)
                begin
                    error_count++;
                    $display("%0t: unexpected result: expected none actual status %0d count %0d",
                             $realtime, status, entry_count);
                end
                else
                begin
                    want = awaited_results.pop_front();
                    if (status !== want.st)
                    begin
                        error_count++;
                        $display("%0t: status mismatch: expected %0d actual %0d",
                                 $realtime, want.st, status);
                    end
                    if (entry_count !== want.count)
                    begin
                        error_count++;
                        $display("%0t: entry_count mismatch: expected %0d actual %0d",
                                 $realtime, want.count, entry_count);
                    end
                end
            end
            if (in_valid && in_ready)
            begin
                taken.fn  = func_t'(func);
                taken.val = value;
                awaited_results.push_back(apply_table_op(taken));
            end
        end
    end

    // Timeout guard
    always @(posedge clk)
    begin
        cycle_count <= cycle_count + 1;
        if (cycle_count >= CYCLE_LIMIT)
        begin
            $display("CHECKS FAILED");
            $finish;
        end
    end

endmodule

/* sim.f */
rtl/sli_pkg.sv
rtl/sli_ram.sv
rtl/sorted_list_insert_delete_unit.sv
bench/tb_top.sv
